>>> sv/fpsl_pkg.sv
//------------------------------------------------------------------------------
// fpsl_pkg
// Shared types and constants for the fog parameter slew limiter.
//------------------------------------------------------------------------------
package fpsl_pkg;

    localparam logic [1:0] MODE_EASE    = 2'd0;
    localparam logic [1:0] MODE_NOSKY   = 2'd1;
    localparam logic [1:0] MODE_SCRATCH = 2'd2;

    localparam logic [1:0] REG_SNAP   = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_MARGIN = 2'd2;

    localparam logic [31:0] SNAP_RESET   = 32'd983040;
    localparam logic [15:0] SCALE_RESET  = 16'd3277;
    localparam logic [15:0] MARGIN_RESET = 16'd7;
    localparam logic [15:0] SCREEN_ONE   = 16'h8000;
    localparam int          SQRT_STEPS   = 32;

    typedef struct packed {
        logic [1:0]         player_slot;
        logic [1:0]         request_mode;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic [31:0]        target_near;
        logic [31:0]        target_far;
        logic [15:0]        target_density;
        logic [15:0]        target_red;
        logic [15:0]        target_green;
        logic [15:0]        target_blue;
        logic               screen_target_on;
    } fog_in_t;

    typedef struct packed {
        logic [31:0] out_near;
        logic [31:0] out_far;
        logic [15:0] out_density;
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_screen;
    } fog_out_t;

    typedef struct packed {
        logic [31:0] near_d;
        logic [31:0] far_d;
        logic [15:0] dens;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] screen;
    } fog_vals_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sq_x;
        logic sq_y;
        logic sq_z;
        logic sqrt_init;
        logic sqrt_step;
        logic cstep;
        logic finish;
    } fpsl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_dist;
        logic sqrt_last;
    } fpsl_sts_t;

endpackage

>>> sv/fpsl_if.sv
//------------------------------------------------------------------------------
// fpsl_if
// Valid/ready channel carrying one item.
//------------------------------------------------------------------------------
interface fpsl_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/fpsl_ctrl.sv
//------------------------------------------------------------------------------
// fpsl_ctrl
// Sequencer: load; for ease items square three axes, root iterations, colour step; finish.
//------------------------------------------------------------------------------
module fpsl_ctrl
    import fpsl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  fpsl_sts_t sts,
    output fpsl_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SQX   = 8'b00000010,
        S_SQY   = 8'b00000100,
        S_SQZ   = 8'b00001000,
        S_ROOT  = 8'b00010000,
        S_CSTEP = 8'b00100000,
        S_FIN   = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                if (sts.need_dist)
                begin
                    cmd.sq_x   = 1'b1;
                    state_next = S_SQY;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SQY:
            begin
                cmd.sq_y   = 1'b1;
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.sq_z      = 1'b1;
                cmd.sqrt_init = 1'b1;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                begin
                    state_next = S_CSTEP;
                end
            end
            S_CSTEP:
            begin
                cmd.cstep  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/fpsl_dp.sv
//------------------------------------------------------------------------------
// fpsl_dp
// Slot state, squared distance, bit-serial square root, easing and output.
//------------------------------------------------------------------------------
module fpsl_dp
    import fpsl_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  fpsl_cmd_t   cmd,
    output fpsl_sts_t   sts,
    input  fog_in_t     in_data,
    input  logic [31:0] snap_distance,
    input  logic [15:0] colour_step_scale,
    input  logic [15:0] far_margin,
    output fog_out_t    out_data
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic signed [31:0] pos_x_reg [NUM_SLOTS];
    logic signed [31:0] pos_y_reg [NUM_SLOTS];
    logic signed [31:0] pos_z_reg [NUM_SLOTS];
    fog_vals_t          cur_reg   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;

    fog_in_t     item_reg;
    logic [63:0] sum_reg;
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] cstep_reg;
    fog_out_t    out_reg;

    logic        in_range;
    logic [SW-1:0] sidx;
    logic [1:0]  mode;
    logic        is_ease;
    logic signed [31:0] cam_sel, last_sel;
    logic signed [32:0] diff;
    logic signed [31:0] dsat;
    logic [63:0] sq;
    fog_vals_t   tgt, cur, res, zero_v;
    logic [31:0] moved;
    logic        snap;
    logic [63:0] trial;
    logic [47:0] cprod;

    assign mode     = (item_reg.request_mode == 2'd3) ? MODE_NOSKY : item_reg.request_mode;
    assign in_range = ({30'd0, item_reg.player_slot} < NUM_SLOTS);
    assign sidx     = SW'(item_reg.player_slot);
    assign is_ease  = in_range && (mode == MODE_EASE);
    assign sts.need_dist = is_ease;
    assign sts.sqrt_last = (cnt_reg == 6'd1);

    always_comb
    begin
        cam_sel  = item_reg.cam_x;
        last_sel = pos_x_reg[sidx];
        if (cmd.sq_y)
        begin
            cam_sel  = item_reg.cam_y;
            last_sel = pos_y_reg[sidx];
        end
        else if (cmd.sq_z)
        begin
            cam_sel  = item_reg.cam_z;
            last_sel = pos_z_reg[sidx];
        end
        diff = 33'(cam_sel) - 33'(last_sel);
        if (diff > 33'sh07FFFFFFF)
        begin
            dsat = 32'sh7FFFFFFF;
        end
        else if (diff < -33'sh080000000)
        begin
            dsat = 32'sh80000000;
        end
        else
        begin
            dsat = diff[31:0];
        end
        sq = 64'(dsat * dsat);
    end

    function automatic logic [31:0] slew32(logic [31:0] c, logic [31:0] t,
                                           logic [31:0] s);
        logic [32:0] d;
        begin
            if (t >= c)
            begin
                d = {1'b0, t} - {1'b0, c};
                slew32 = (d > {1'b0, s}) ? c + s : t;
            end
            else
            begin
                d = {1'b0, c} - {1'b0, t};
                slew32 = (d > {1'b0, s}) ? c - s : t;
            end
        end
    endfunction

    function automatic logic [15:0] slew16(logic [15:0] c, logic [15:0] t,
                                           logic [31:0] s);
        begin
            slew16 = 16'(slew32({16'd0, c}, {16'd0, t}, s));
        end
    endfunction

    always_comb
    begin
        tgt.near_d = item_reg.target_near;
        tgt.far_d  = item_reg.target_far;
        tgt.dens   = item_reg.target_density;
        tgt.red    = item_reg.target_red;
        tgt.green  = item_reg.target_green;
        tgt.blue   = item_reg.target_blue;
        tgt.screen = item_reg.screen_target_on ? SCREEN_ONE : 16'd0;
        zero_v     = '0;
        cur        = cur_reg[sidx];
        moved      = root_reg[31:0];
        snap = (moved >= snap_distance) || !valid_reg[sidx] ||
               (tgt.far_d == 32'd0) || (cur.far_d == 32'd0);
        if (snap)
        begin
            res = tgt;
        end
        else
        begin
            res.near_d = slew32(cur.near_d, tgt.near_d, moved);
            res.far_d  = slew32(cur.far_d, tgt.far_d, moved);
            res.dens   = slew16(cur.dens, tgt.dens, cstep_reg);
            res.red    = slew16(cur.red, tgt.red, cstep_reg);
            res.green  = slew16(cur.green, tgt.green, cstep_reg);
            res.blue   = slew16(cur.blue, tgt.blue, cstep_reg);
            res.screen = slew16(cur.screen, tgt.screen, cstep_reg);
        end
        trial = rem_reg;
        cprod = 48'(moved) * 48'(colour_step_scale);
    end

    function automatic fog_out_t emit(fog_vals_t v, logic [15:0] m);
        logic [32:0] fl;
        begin
            fl = {1'b0, v.near_d} + {17'd0, m};
            emit.out_near = v.near_d;
            emit.out_far  = v.far_d;
            if ((v.far_d != 32'd0) && ({1'b0, v.far_d} <= fl))
            begin
                emit.out_far = fl[32] ? 32'hFFFFFFFF : fl[31:0];
            end
            emit.out_density = v.dens;
            emit.out_red     = v.red;
            emit.out_green   = v.green;
            emit.out_blue    = v.blue;
            emit.out_screen  = (v.screen > SCREEN_ONE) ? SCREEN_ONE : v.screen;
        end
    endfunction

    logic [63:0] bit_w;
    logic [64:0] rb;
    always_comb
    begin
        bit_w = 64'd1 << {cnt_reg - 6'd1, 1'b0};
        rb    = {1'b0, root_reg} + {1'b0, bit_w};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.sq_x)
        begin
            sum_reg <= sq;
        end
        if (cmd.sq_y)
        begin
            sum_reg <= sum_reg + sq;
        end
        if (cmd.sqrt_init)
        begin
            rem_reg  <= sum_reg + sq;
            root_reg <= '0;
            cnt_reg  <= 6'(SQRT_STEPS);
        end
        if (cmd.sqrt_step)
        begin
            if ({1'b0, trial} >= rb)
            begin
                rem_reg  <= trial - rb[63:0];
                root_reg <= (root_reg >> 1) + bit_w;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            cnt_reg <= cnt_reg - 6'd1;
        end
        if (cmd.cstep)
        begin
            cstep_reg <= 32'(cprod >> 17);
        end
        if (cmd.finish)
        begin
            if (!in_range)
            begin
                out_reg <= emit((mode == MODE_NOSKY) ? zero_v : tgt, far_margin);
            end
            else if (mode == MODE_SCRATCH)
            begin
                out_reg <= emit(tgt, far_margin);
            end
            else if (mode == MODE_EASE)
            begin
                out_reg <= emit(res, far_margin);
            end
            else
            begin
                out_reg <= emit(cur, far_margin);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                pos_x_reg[i] <= '0;
                pos_y_reg[i] <= '0;
                pos_z_reg[i] <= '0;
                cur_reg[i]   <= '0;
            end
        end
        else if (cmd.finish && is_ease)
        begin
            cur_reg[sidx]   <= res;
            valid_reg[sidx] <= 1'b1;
            pos_x_reg[sidx] <= item_reg.cam_x;
            pos_y_reg[sidx] <= item_reg.cam_y;
            pos_z_reg[sidx] <= item_reg.cam_z;
        end
    end

    assign out_data = out_reg;

endmodule

>>> sv/fog_parameter_slew_limiter.sv
//------------------------------------------------------------------------------
// fog_parameter_slew_limiter
// Eases per-viewer fog values toward targets by the distance the camera moved.
//------------------------------------------------------------------------------
// channel   dir  payload
// fog_in    in   slot, mode, camera position, fog targets
// fog_out   out  fog values: eased, target, current or zero by mode
// apb       in   snap_distance, colour_step_scale, far_margin
//
// Ease items pass the three squaring states, the 32-step bit-serial square
// root and the colour step before finish; other items go straight to finish.
// One item at a time: a new item is taken only once the last result is taken.
// Reset clears slot state, sets APB registers to defaults; no clearing pass.
// A stalled result holds the block until taken.
//------------------------------------------------------------------------------
module fog_parameter_slew_limiter
    import fpsl_pkg::*;
#(
    parameter int NUM_SLOTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    fpsl_if.sink        fog_in,
    fpsl_if.source      fog_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] snap_reg;
    logic [15:0] scale_reg;
    logic [15:0] margin_reg;
    fpsl_cmd_t   cmd;
    fpsl_sts_t   sts;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_reg   <= SNAP_RESET;
            scale_reg  <= SCALE_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (wr && (paddr[1:0] == 2'd0))
        begin
            unique case (paddr[3:2])
                REG_SNAP:   snap_reg   <= pwdata;
                REG_SCALE:  scale_reg  <= pwdata[15:0];
                REG_MARGIN: margin_reg <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SNAP:   prdata = snap_reg;
            REG_SCALE:  prdata = {16'd0, scale_reg};
            REG_MARGIN: prdata = {16'd0, margin_reg};
            default:    prdata = '0;
        endcase
    end

    fpsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fog_in.valid),
        .in_ready  (fog_in.ready),
        .out_valid (fog_out.valid),
        .out_ready (fog_out.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fpsl_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .in_data           (fog_in.data),
        .snap_distance     (snap_reg),
        .colour_step_scale (scale_reg),
        .far_margin        (margin_reg),
        .out_data          (fog_out.data)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(fog_in.ready && fog_out.valid))
        else $error("input ready while result pending");

    a_finish_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> fog_out.valid)
        else $error("result not shown after finish");

    a_screen_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        fog_out.valid |-> (fog_out.data.out_screen <= SCREEN_ONE))
        else $error("screen intensity out of range");

endmodule
